FILE: hdl/cthp_pkg.sv
package cthp_pkg;

    // default depth of the queue between classifier and parser
    localparam int QUEUE_DEPTH_DEF = 2;

    // characters with a syntactic role
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_HT     = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_SP     = 8'h20;
    localparam logic [7:0] CHAR_SLASH  = 8'h2f;
    localparam logic [7:0] CHAR_SEMI   = 8'h3b;
    localparam logic [7:0] CHAR_EQ     = 8'h3d;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5c;

    // character kinds reported with an accepted character
    localparam logic [1:0] KIND_TYPE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_VAL  = 2'd2;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_TYPE   = 4'd1,
        PH_SUB0   = 4'd2,
        PH_SUB    = 4'd3,
        PH_AFTER  = 4'd4,
        PH_NAME0  = 4'd5,
        PH_NAME   = 4'd6,
        PH_VAL0   = 4'd7,
        PH_VALTOK = 4'd8,
        PH_QUOTED = 4'd9,
        PH_ESC    = 4'd10,
        PH_REJECT = 4'd11
    } cthp_phase_t;

    // character class flags
    typedef struct packed {
        logic token;
        logic lws;
        logic text;
        logic chr;
    } cthp_class_t;

    // one classified byte
    typedef struct packed {
        logic [7:0]  byte_val;
        cthp_class_t cls;
    } cthp_item_t;

    // one result item
    typedef struct packed {
        logic       char_valid;
        logic [1:0] char_kind;
        logic [7:0] char_value;
        logic       type_done;
        logic       attr_done;
        logic       header_end;
        logic       header_ok;
        logic       syntax_error;
    } cthp_result_t;

endpackage

FILE: hdl/cthp_front.sv
module cthp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_byte,
    output logic               item_valid,
    input  logic               item_ready,
    output cthp_pkg::cthp_item_t item
);
    import cthp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    cthp_item_t  item_reg;
    cthp_class_t cls;
    logic        sep;

    // separators excluded from the token class
    always_comb
    begin
        case (char_byte)
            8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
            8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d: sep = 1'b1;
            default: sep = 1'b0;
        endcase
    end

    always_comb
    begin
        cls.chr   = ~char_byte[7];
        cls.lws   = (char_byte == CHAR_HT) || (char_byte == CHAR_LF) ||
                    (char_byte == CHAR_CR) || (char_byte == CHAR_SP);
        cls.text  = cls.lws || char_byte[7] ||
                    ((char_byte >= 8'd32) && (char_byte <= 8'd126));
        cls.token = (char_byte >= 8'd33) && (char_byte <= 8'd126) && !sep;
    end

    assign in_ready   = !valid_reg || item_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.byte_val <= char_byte;
            item_reg.cls      <= cls;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/cthp_queue.sv
module cthp_queue #(
    parameter int DEPTH = cthp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  cthp_pkg::cthp_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output cthp_pkg::cthp_item_t pop_item
);
    import cthp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    cthp_item_t      mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("queue count beyond depth");

endmodule

FILE: hdl/cthp_back.sv
module cthp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  cthp_pkg::cthp_item_t   item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output cthp_pkg::cthp_result_t res
);
    import cthp_pkg::*;

    cthp_phase_t  phase_reg, phase_next;
    cthp_result_t res_reg, res_next;
    logic         valid_reg, valid_next;
    logic         pop;
    logic [7:0]   b;
    cthp_class_t  c;
    logic         is_nul;

    assign b      = item.byte_val;
    assign c      = item.cls;
    assign is_nul = (b == CHAR_NUL);

    assign item_ready = !valid_reg || res_ready;
    assign pop        = item_valid && item_ready;
    assign valid_next = pop || (valid_reg && !res_ready);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_LEAD:
            begin
                if (c.lws)        phase_next = PH_LEAD;
                else if (c.token) phase_next = PH_TYPE;
                else              phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_TYPE:
            begin
                if (c.token)                phase_next = PH_TYPE;
                else if (b == CHAR_SLASH)   phase_next = PH_SUB0;
                else                        phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_SUB0:
            begin
                if (c.token) phase_next = PH_SUB;
                else         phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_SUB, PH_VALTOK, PH_AFTER:
            begin
                if (c.token && phase_reg != PH_AFTER) phase_next = phase_reg;
                else if (c.lws)                       phase_next = PH_AFTER;
                else if (is_nul)                      phase_next = PH_LEAD;
                else if (b == CHAR_SEMI)              phase_next = PH_NAME0;
                else                                  phase_next = PH_REJECT;
            end
            PH_NAME0:
            begin
                if (c.lws)        phase_next = PH_NAME0;
                else if (c.token) phase_next = PH_NAME;
                else              phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_NAME:
            begin
                if (c.token)          phase_next = PH_NAME;
                else if (b == CHAR_EQ) phase_next = PH_VAL0;
                else                  phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_VAL0:
            begin
                if (b == CHAR_DQUOTE) phase_next = PH_QUOTED;
                else if (c.token)     phase_next = PH_VALTOK;
                else                  phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_QUOTED:
            begin
                if (b == CHAR_DQUOTE)      phase_next = PH_AFTER;
                else if (b == CHAR_BSLASH) phase_next = PH_ESC;
                else if (c.text)           phase_next = PH_QUOTED;
                else                       phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            PH_ESC:
            begin
                if (!is_nul && c.chr) phase_next = PH_QUOTED;
                else                  phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
            default:
            begin
                phase_next = is_nul ? PH_LEAD : PH_REJECT;
            end
        endcase
    end

    // result of this byte
    always_comb
    begin
        res_next = '0;
        case (phase_reg)
            PH_LEAD:
            begin
                if (c.lws)
                begin
                end
                else if (c.token)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_TYPE;
                    res_next.char_value = b;
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            PH_TYPE, PH_SUB0:
            begin
                if (c.token || (phase_reg == PH_TYPE && b == CHAR_SLASH))
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_TYPE;
                    res_next.char_value = b;
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            PH_SUB, PH_VALTOK, PH_AFTER:
            begin
                if (c.token && phase_reg != PH_AFTER)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = (phase_reg == PH_SUB) ? KIND_TYPE : KIND_VAL;
                    res_next.char_value = b;
                end
                else
                begin
                    // token ends here, byte then judged as separator
                    res_next.type_done = (phase_reg == PH_SUB);
                    res_next.attr_done = (phase_reg == PH_VALTOK);
                    if (c.lws || b == CHAR_SEMI)
                    begin
                    end
                    else if (is_nul)
                    begin
                        res_next.header_end = 1'b1;
                        res_next.header_ok  = 1'b1;
                    end
                    else
                    begin
                        res_next.syntax_error = 1'b1;
                    end
                end
            end
            PH_NAME0, PH_NAME:
            begin
                if (c.token)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_NAME;
                    res_next.char_value = b;
                end
                else if ((phase_reg == PH_NAME0 && c.lws) ||
                         (phase_reg == PH_NAME && b == CHAR_EQ))
                begin
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            PH_VAL0:
            begin
                if (b == CHAR_DQUOTE)
                begin
                end
                else if (c.token)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_VAL;
                    res_next.char_value = b;
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            PH_QUOTED:
            begin
                if (b == CHAR_DQUOTE)
                begin
                    res_next.attr_done = 1'b1;
                end
                else if (b == CHAR_BSLASH)
                begin
                end
                else if (c.text)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_VAL;
                    res_next.char_value = b;
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            PH_ESC:
            begin
                if (!is_nul && c.chr)
                begin
                    res_next.char_valid = 1'b1;
                    res_next.char_kind  = KIND_VAL;
                    res_next.char_value = b;
                end
                else
                begin
                    res_next.syntax_error = 1'b1;
                    res_next.header_end   = is_nul;
                end
            end
            default:
            begin
                // rejected header: silent until the terminating zero
                res_next.header_end = is_nul;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

    a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.header_ok |-> res_reg.header_end)
        else $error("header_ok without header_end");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.header_end |-> phase_reg == PH_LEAD)
        else $error("parser did not restart after header end");

    a_err_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && res_reg.syntax_error && !res_reg.header_end
        |-> phase_reg == PH_REJECT)
        else $error("syntax error did not enter reject phase");

    a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.char_valid
        |-> res_reg.char_kind == KIND_TYPE && res_reg.char_value == CHAR_NUL)
        else $error("char fields set without char_valid");

endmodule

FILE: hdl/content_type_header_parser.sv
// content-type header parser, one header byte per item
//
// input channel: in_valid/in_ready carry char_byte; a zero byte ends the header
// output channel: out_valid/out_ready carry one result item per input item:
//   char_valid/char_kind/char_value, type_done, attr_done, header_end,
//   header_ok and syntax_error
// structure: a classifier stage registers each byte with its token, lws, text
//   and char flags, a short queue follows, and the parser state machine pops
//   the queue and fills the output register
// path: an accepted byte passes the classifier register, the queue and the
//   output register before its result shows on out_valid
// throughput: one item per cycle while out_ready is high; the parser phase is
//   updated once per popped byte, which sets that rate
// stall: while out_ready is low the output register holds, the queue fills,
//   then in_ready drops; accept resumes the cycle after out_ready rises
// reset: all stages empty, parser back in the leading whitespace phase
// after a syntax error all bytes up to the zero byte give an all-zero result,
//   the zero byte then reports a rejected header and the parser restarts
module content_type_header_parser #(
    parameter int QUEUE_DEPTH = cthp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [1:0] char_kind,
    output logic [7:0] char_value,
    output logic       type_done,
    output logic       attr_done,
    output logic       header_end,
    output logic       header_ok,
    output logic       syntax_error
);
    import cthp_pkg::*;

    // classifier to queue
    logic         f_valid;
    logic         f_ready;
    cthp_item_t   f_item;

    // queue to parser
    logic         q_valid;
    logic         q_ready;
    cthp_item_t   q_item;

    cthp_result_t res;

    cthp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_byte  (char_byte),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    cthp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    cthp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    // result fields straight from the output register
    assign char_valid   = res.char_valid;
    assign char_kind    = res.char_kind;
    assign char_value   = res.char_value;
    assign type_done    = res.type_done;
    assign attr_done    = res.attr_done;
    assign header_end   = res.header_end;
    assign header_ok    = res.header_ok;
    assign syntax_error = res.syntax_error;

endmodule
